### rtl/pdfc_pkg.sv
// Package for the packet duplicate filter: controller states, command and
// status structs, hash constants and configuration register indexes.
// No dependencies; every other file but pdfc_ram imports it.
package pdfc_pkg;

  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;
  localparam logic [7:0]  MIN_PATH_FOR_SOURCE = 8'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TRACE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DIRECT  = 2'd2;

  localparam logic [31:0] TIMEOUT_RESET = 32'd60000;
  localparam logic [3:0]  TRACE_RESET   = 4'd9;
  localparam logic [1:0]  DIRECT_RESET  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR_VER,
    ST_TRACE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_DONE
  } pdfc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic hdr_load;
    logic byte_fold;
    logic ver_fold;
    logic trace_fold;
    logic scan_clear;
    logic scan_read;
    logic finish;
  } pdfc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
  } pdfc_status_t;

endpackage

### rtl/pdfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pdfc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/pdfc_ctrl.sv
// Controller state machine of the packet duplicate filter.
// Depends on pdfc_pkg for the state enum and the command/status structs.
module pdfc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   in_mode,
  input  logic                   in_last,
  input  pdfc_pkg::pdfc_status_t status,
  output logic                   busy,
  output pdfc_pkg::pdfc_cmd_t    cmd
);
  import pdfc_pkg::*;

  pdfc_state_t state_r, state_nxt;
  logic        last_r, last_nxt;
  logic        accept;

  assign accept = start && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    last_nxt  = accept ? in_last : last_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (!in_mode) begin
            state_nxt = ST_HDR_VER;
          end else if (in_last) begin
            state_nxt = ST_TRACE;
          end
        end
      end
      ST_HDR_VER:   state_nxt = last_r ? ST_TRACE : ST_IDLE;
      ST_TRACE:     state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (status.scan_last) begin
          state_nxt = ST_SCAN_LAST;
        end
      end
      ST_SCAN_LAST: state_nxt = ST_DONE;
      ST_DONE:      state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy          = 1'b0;
        cmd.hdr_load  = start && !in_mode;
        cmd.byte_fold = start && in_mode;
      end
      ST_HDR_VER: cmd.ver_fold = 1'b1;
      ST_TRACE: begin
        cmd.trace_fold = 1'b1;
        cmd.scan_clear = 1'b1;
      end
      ST_SCAN:      cmd.scan_read = 1'b1;
      ST_SCAN_LAST: cmd = '0;
      ST_DONE:      cmd.finish = 1'b1;
      default:      busy = 1'b1;
    endcase
  end

endmodule

### rtl/pdfc_datapath.sv
// Datapath of the packet duplicate filter: hash register with one shared
// FNV-1a fold unit, held header, config registers, cache RAM and scan logic.
// Depends on pdfc_pkg and pdfc_ram.
module pdfc_datapath #(
  parameter int CACHE_ENTRIES = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pdfc_pkg::pdfc_cmd_t               cmd,
  output pdfc_pkg::pdfc_status_t            status,
  input  logic                              cfg_we,
  input  logic [pdfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pdfc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [3:0]                        in_payload_type,
  input  logic [1:0]                        in_payload_version,
  input  logic [1:0]                        in_route_type,
  input  logic [7:0]                        in_path_length,
  input  logic                              in_has_transport_code,
  input  logic [15:0]                       in_transport_code,
  input  logic [15:0]                       in_path_head,
  input  logic [31:0]                       in_packet_time,
  input  logic [7:0]                        in_payload_byte,
  output logic                              out_valid,
  output logic                              out_is_duplicate,
  output logic [31:0]                       out_packet_hash,
  output logic [15:0]                       out_source_node,
  output logic [31:0]                       out_duplicate_total
);
  import pdfc_pkg::*;

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

  // Configuration registers.
  logic [31:0] timeout_r;
  logic [3:0]  trace_code_r;
  logic [1:0]  direct_code_r;

  // Held header and running hash.
  logic [31:0] hash_r, hash_nxt;
  logic [3:0]  h_type_r;
  logic [1:0]  h_ver_r;
  logic [1:0]  h_route_r;
  logic [7:0]  h_plen_r;
  logic        h_has_tc_r;
  logic [15:0] h_tc_r;
  logic [15:0] h_phead_r;
  logic [31:0] h_time_r;

  // Cache bookkeeping.
  logic [CACHE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]         slot_r, slot_nxt;
  logic [IDX_W-1:0]         scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]         cmp_idx_r;
  logic                     cmp_vld_r;
  logic                     dup_r, dup_nxt;
  logic [31:0]              dup_cnt_r, dup_cnt_nxt;

  // Output registers.
  logic        out_valid_r;
  logic        out_dup_r;
  logic [31:0] out_hash_r;
  logic [15:0] out_src_r;
  logic [31:0] out_total_r;

  // Fold unit.
  logic [31:0] fold_h;
  logic [7:0]  fold_v;
  logic [31:0] fold_res;
  logic        trace_match;

  // Cache RAM.
  logic [63:0] ram_rdata;
  logic [31:0] rd_hash;
  logic [31:0] rd_time;
  logic [31:0] age;
  logic        entry_live;
  logic        expired;
  logic [15:0] src_sel;

  assign trace_match = (h_type_r == trace_code_r) && (h_route_r == direct_code_r);

  always_comb begin
    fold_h = hash_r;
    fold_v = in_payload_byte;
    if (cmd.hdr_load) begin
      fold_h = HASH_BASIS;
      fold_v = {4'd0, in_payload_type};
    end else if (cmd.ver_fold) begin
      fold_v = {6'd0, h_ver_r};
    end else if (cmd.trace_fold) begin
      fold_v = h_plen_r;
    end
  end

  assign fold_res = (fold_h ^ {24'd0, fold_v}) * HASH_PRIME;

  always_comb begin
    hash_nxt = hash_r;
    if (cmd.hdr_load || cmd.byte_fold || cmd.ver_fold) begin
      hash_nxt = fold_res;
    end else if (cmd.trace_fold && trace_match) begin
      hash_nxt = fold_res;
    end else if (cmd.finish) begin
      hash_nxt = HASH_BASIS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r     <= TIMEOUT_RESET;
      trace_code_r  <= TRACE_RESET;
      direct_code_r <= DIRECT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_TIMEOUT: timeout_r     <= cfg_data[31:0];
        CFG_IDX_TRACE:   trace_code_r  <= cfg_data[3:0];
        CFG_IDX_DIRECT:  direct_code_r <= cfg_data[1:0];
        default:         timeout_r     <= timeout_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r     <= HASH_BASIS;
      h_type_r   <= '0;
      h_ver_r    <= '0;
      h_route_r  <= '0;
      h_plen_r   <= '0;
      h_has_tc_r <= 1'b0;
      h_tc_r     <= '0;
      h_phead_r  <= '0;
      h_time_r   <= '0;
    end else begin
      hash_r <= hash_nxt;
      if (cmd.hdr_load) begin
        h_type_r   <= in_payload_type;
        h_ver_r    <= in_payload_version;
        h_route_r  <= in_route_type;
        h_plen_r   <= in_path_length;
        h_has_tc_r <= in_has_transport_code;
        h_tc_r     <= in_transport_code;
        h_phead_r  <= in_path_head;
        h_time_r   <= in_packet_time;
      end
    end
  end

  pdfc_ram #(
    .WIDTH (64),
    .DEPTH (CACHE_ENTRIES)
  ) u_cache_ram (
    .clk   (clk),
    .we    (cmd.finish && !dup_r),
    .waddr (slot_r),
    .wdata ({hash_r, h_time_r}),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  assign rd_hash = ram_rdata[63:32];
  assign rd_time = ram_rdata[31:0];

  // An entry past the timeout is dropped; only entries that survive can match.
  assign age        = h_time_r - rd_time;
  assign expired    = age > timeout_r;
  assign entry_live = cmp_vld_r && valid_r[cmp_idx_r];

  assign status.scan_last = (scan_idx_r == LAST_IDX);

  always_comb begin
    valid_nxt    = valid_r;
    dup_nxt      = dup_r;
    slot_nxt     = slot_r;
    dup_cnt_nxt  = dup_cnt_r;
    scan_idx_nxt = scan_idx_r;
    if (cmd.scan_clear) begin
      scan_idx_nxt = '0;
      dup_nxt      = 1'b0;
    end else if (cmd.scan_read) begin
      scan_idx_nxt = scan_idx_r + 1'b1;
    end
    if (entry_live) begin
      if (expired) begin
        valid_nxt[cmp_idx_r] = 1'b0;
      end else if (rd_hash == hash_r) begin
        dup_nxt = 1'b1;
      end
    end
    if (cmd.finish) begin
      if (dup_r) begin
        dup_cnt_nxt = dup_cnt_r + 32'd1;
      end else begin
        valid_nxt[slot_r] = 1'b1;
        slot_nxt = (slot_r == LAST_IDX) ? '0 : slot_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      dup_r      <= 1'b0;
      slot_r     <= '0;
      dup_cnt_r  <= '0;
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
      cmp_idx_r  <= '0;
    end else begin
      valid_r    <= valid_nxt;
      dup_r      <= dup_nxt;
      slot_r     <= slot_nxt;
      dup_cnt_r  <= dup_cnt_nxt;
      scan_idx_r <= scan_idx_nxt;
      cmp_vld_r  <= cmd.scan_read;
      cmp_idx_r  <= scan_idx_r;
    end
  end

  always_comb begin
    if (dup_r) begin
      src_sel = '0;
    end else if (h_has_tc_r) begin
      src_sel = h_tc_r;
    end else if (h_plen_r >= MIN_PATH_FOR_SOURCE) begin
      src_sel = h_phead_r;
    end else begin
      src_sel = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_dup_r   <= dup_r;
      out_hash_r  <= hash_r;
      out_src_r   <= src_sel;
      out_total_r <= dup_cnt_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_is_duplicate    = out_dup_r;
  assign out_packet_hash     = out_hash_r;
  assign out_source_node     = out_src_r;
  assign out_duplicate_total = out_total_r;

endmodule

### rtl/packet_dedup_fnv_cache_unit.sv
// Top level of the packet duplicate filter: controller plus datapath.
// Depends on pdfc_pkg, pdfc_ctrl, pdfc_datapath and pdfc_ram.
//
// A packet is one header transaction (in_mode 0) followed by payload byte
// transactions (in_mode 1); the transaction with in_last high closes it and
// yields one result, shown for a single cycle with out_valid high, which the
// receiver cannot stall. A payload byte that does not close the packet leaves
// busy low, and a header that does not close it holds busy high in ST_HDR_VER,
// since the FNV-1a fold unit handles one byte per cycle. Closing scans the cache
// through the single read port of its RAM, one entry per cycle: busy stays high
// through ST_TRACE, ST_SCAN, ST_SCAN_LAST and ST_DONE after a closing payload
// byte (after a closing header, ST_HDR_VER first), and out_valid is high in the
// first cycle in which busy is low again. Configuration writes are taken at any
// clock edge and belong only in cycles where busy is low.
module packet_dedup_fnv_cache_unit #(
  parameter int CACHE_ENTRIES = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_mode,
  input  logic                              in_last,
  input  logic [3:0]                        in_payload_type,
  input  logic [1:0]                        in_payload_version,
  input  logic [1:0]                        in_route_type,
  input  logic [7:0]                        in_path_length,
  input  logic                              in_has_transport_code,
  input  logic [15:0]                       in_transport_code,
  input  logic [15:0]                       in_path_head,
  input  logic [31:0]                       in_packet_time,
  input  logic [7:0]                        in_payload_byte,
  output logic                              out_valid,
  output logic                              out_is_duplicate,
  output logic [31:0]                       out_packet_hash,
  output logic [15:0]                       out_source_node,
  output logic [31:0]                       out_duplicate_total,
  input  logic                              cfg_we,
  input  logic [pdfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pdfc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pdfc_pkg::*;

  pdfc_cmd_t    cmd;
  pdfc_status_t status;

  pdfc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .in_last (in_last),
    .status  (status),
    .busy    (busy),
    .cmd     (cmd)
  );

  pdfc_datapath #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .status                (status),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_payload_type       (in_payload_type),
    .in_payload_version    (in_payload_version),
    .in_route_type         (in_route_type),
    .in_path_length        (in_path_length),
    .in_has_transport_code (in_has_transport_code),
    .in_transport_code     (in_transport_code),
    .in_path_head          (in_path_head),
    .in_packet_time        (in_packet_time),
    .in_payload_byte       (in_payload_byte),
    .out_valid             (out_valid),
    .out_is_duplicate      (out_is_duplicate),
    .out_packet_hash       (out_packet_hash),
    .out_source_node       (out_source_node),
    .out_duplicate_total   (out_duplicate_total)
  );

endmodule

### tb/tb_packet_dedup_fnv_cache_unit.sv
// Self-checking testbench for packet_dedup_fnv_cache_unit: drives packet transactions,
// predicts every FNV-1a duplicate-filter result and compares it field by field.
// Depends on pdfc_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_packet_dedup_fnv_cache_unit;
  import pdfc_pkg::*;

  localparam int CACHE_ENTRIES = 32;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = CACHE_ENTRIES + 8;
  localparam int POOL_DEPTH = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef struct {
    logic        mode;
    logic        last;
    logic [3:0]  ptype;
    logic [1:0]  pver;
    logic [1:0]  route;
    logic [7:0]  plen;
    logic        has_tc;
    logic [15:0] tc;
    logic [15:0] phead;
    logic [31:0] ptime;
    logic [7:0]  pbyte;
  } pkt_item_t;

  typedef struct {
    logic        dup;
    logic [31:0] hash;
    logic [15:0] src;
    logic [31:0] total;
  } dedup_result_t;

  // Hash-relevant content of a packet, kept so that it can be replayed as a duplicate.
  typedef struct {
    logic [3:0] ptype;
    logic [1:0] pver;
    logic [1:0] route;
    logic [7:0] plen;
    int         nbytes;
    logic [7:0] data [0:19];
  } pkt_tmpl_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = 1'b0;
  logic in_last = 1'b0;
  logic [3:0] in_payload_type = '0;
  logic [1:0] in_payload_version = '0;
  logic [1:0] in_route_type = '0;
  logic [7:0] in_path_length = '0;
  logic in_has_transport_code = 1'b0;
  logic [15:0] in_transport_code = '0;
  logic [15:0] in_path_head = '0;
  logic [31:0] in_packet_time = '0;
  logic [7:0] in_payload_byte = '0;
  logic out_valid;
  logic out_is_duplicate;
  logic [31:0] out_packet_hash;
  logic [15:0] out_source_node;
  logic [31:0] out_duplicate_total;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  packet_dedup_fnv_cache_unit #(.CACHE_ENTRIES(CACHE_ENTRIES)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_mode(in_mode),
    .in_last(in_last),
    .in_payload_type(in_payload_type),
    .in_payload_version(in_payload_version),
    .in_route_type(in_route_type),
    .in_path_length(in_path_length),
    .in_has_transport_code(in_has_transport_code),
    .in_transport_code(in_transport_code),
    .in_path_head(in_path_head),
    .in_packet_time(in_packet_time),
    .in_payload_byte(in_payload_byte),
    .out_valid(out_valid),
    .out_is_duplicate(out_is_duplicate),
    .out_packet_hash(out_packet_hash),
    .out_source_node(out_source_node),
    .out_duplicate_total(out_duplicate_total),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pkt_item_t pending_items [$];
  dedup_result_t dedup_expected [$];
  pkt_tmpl_t tmpl_pool [$];

  // Predictor state and its copy of the configuration registers.
  logic [31:0] cfg_timeout = TIMEOUT_RESET;
  logic [3:0]  cfg_trace = TRACE_RESET;
  logic [1:0]  cfg_direct = DIRECT_RESET;
  logic [31:0] run_hash = HASH_BASIS;
  pkt_item_t   held_hdr = '{default: '0};
  logic [31:0] slot_hash [0:CACHE_ENTRIES-1];
  logic [31:0] slot_time [0:CACHE_ENTRIES-1];
  bit          slot_valid [0:CACHE_ENTRIES-1] = '{default: 1'b0};
  int unsigned next_slot = 0;
  logic [31:0] dup_count = '0;

  int unsigned mismatches = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_cycles = 0;
  logic in_taken = 1'b0;
  logic [31:0] pkt_clock = '0;

  function automatic logic [31:0] fnv_fold(logic [31:0] h, logic [7:0] v);
    return (h ^ {24'd0, v}) * HASH_PRIME;
  endfunction

  task automatic predict_dedup(pkt_item_t it);
    logic [31:0] h;
    bit hit;
    dedup_result_t res;
    if (!it.mode) begin
      held_hdr = it;
      run_hash = fnv_fold(fnv_fold(HASH_BASIS, {4'd0, it.ptype}), {6'd0, it.pver});
    end else begin
      run_hash = fnv_fold(run_hash, it.pbyte);
    end
    if (it.last) begin
      h = run_hash;
      hit = 1'b0;
      if (held_hdr.ptype == cfg_trace && held_hdr.route == cfg_direct)
        h = fnv_fold(h, held_hdr.plen);
      // Expiry uses the wrapping difference, so a clock that steps back looks very old.
      for (int i = 0; i < CACHE_ENTRIES; i++)
        if (slot_valid[i] && (held_hdr.ptime - slot_time[i]) > cfg_timeout)
          slot_valid[i] = 1'b0;
      for (int i = 0; i < CACHE_ENTRIES; i++)
        if (slot_valid[i] && slot_hash[i] == h) hit = 1'b1;
      res.src = '0;
      if (hit) begin
        dup_count = dup_count + 32'd1;
      end else begin
        slot_hash[next_slot] = h;
        slot_time[next_slot] = held_hdr.ptime;
        slot_valid[next_slot] = 1'b1;
        next_slot = (next_slot + 1) % CACHE_ENTRIES;
        if (held_hdr.has_tc) res.src = held_hdr.tc;
        else if (held_hdr.plen >= MIN_PATH_FOR_SOURCE) res.src = held_hdr.phead;
      end
      res.dup = hit;
      res.hash = h;
      res.total = dup_count;
      dedup_expected.push_back(res);
      run_hash = HASH_BASIS;
    end
  endtask

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    dedup_result_t want;
    if (dedup_expected.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result: expected none, actual hash %h", $time,
               out_packet_hash);
    end else begin
      want = dedup_expected.pop_front();
      cmp_field("is_duplicate", {31'd0, want.dup}, {31'd0, out_is_duplicate});
      cmp_field("packet_hash", want.hash, out_packet_hash);
      cmp_field("source_node", {16'd0, want.src}, {16'd0, out_source_node});
      cmp_field("duplicate_total", want.total, out_duplicate_total);
    end
  endtask

  // Driver: a transaction stays on the port until the block takes it.
  always @(negedge clk) begin : drive_proc
    pkt_item_t it;
    int unsigned calm_left;
    bit skip;
    if (!(start && !in_taken)) begin
      if (calm_left == 0 && $urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 60);
      if (calm_left > 0) begin
        calm_left--;
        skip = 1'b0;
      end else begin
        skip = ($urandom_range(0, 99) < idle_pct);
      end
      if (pending_items.size() > 0 && !skip) begin
        it = pending_items.pop_front();
        in_mode <= it.mode;
        in_last <= it.last;
        in_payload_type <= it.ptype;
        in_payload_version <= it.pver;
        in_route_type <= it.route;
        in_path_length <= it.plen;
        in_has_transport_code <= it.has_tc;
        in_transport_code <= it.tc;
        in_path_head <= it.phead;
        in_packet_time <= it.ptime;
        in_payload_byte <= it.pbyte;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor_proc
    pkt_item_t seen;
    in_taken <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_valid) check_result();
      if (start && !busy) begin
        seen.mode = in_mode;
        seen.last = in_last;
        seen.ptype = in_payload_type;
        seen.pver = in_payload_version;
        seen.route = in_route_type;
        seen.plen = in_path_length;
        seen.has_tc = in_has_transport_code;
        seen.tc = in_transport_code;
        seen.phead = in_path_head;
        seen.ptime = in_packet_time;
        seen.pbyte = in_payload_byte;
        predict_dedup(seen);
      end
    end
  end

  always @(posedge clk) begin : watchdog_proc
    if (!rst_n || (start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic pkt_item_t rand_item();
    pkt_item_t it;
    it.mode = 1'($urandom);
    it.last = 1'($urandom);
    it.ptype = 4'($urandom);
    it.pver = 2'($urandom);
    it.route = 2'($urandom);
    it.plen = 8'($urandom);
    it.has_tc = 1'($urandom);
    it.tc = 16'($urandom);
    it.phead = 16'($urandom);
    it.ptime = $urandom;
    it.pbyte = 8'($urandom);
    return it;
  endfunction

  function automatic void push_hdr(logic last, logic [3:0] ptype, logic [1:0] pver,
                                   logic [1:0] route, logic [7:0] plen, logic has_tc,
                                   logic [15:0] tc, logic [15:0] phead, logic [31:0] ptime);
    pkt_item_t it;
    it = rand_item();
    it.mode = 1'b0;
    it.last = last;
    it.ptype = ptype;
    it.pver = pver;
    it.route = route;
    it.plen = plen;
    it.has_tc = has_tc;
    it.tc = tc;
    it.phead = phead;
    it.ptime = ptime;
    pending_items.push_back(it);
  endfunction

  function automatic void push_byte(logic last, logic [7:0] b);
    pkt_item_t it;
    it = rand_item();
    it.mode = 1'b1;
    it.last = last;
    it.pbyte = b;
    pending_items.push_back(it);
  endfunction

  function automatic void advance_clock(int unsigned step);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) pkt_clock = pkt_clock + $urandom_range(1, step);
    else if (r < 85) pkt_clock = pkt_clock;
    else if (r < 95) pkt_clock = $urandom;
    else pkt_clock = 32'hFFFF_FF00 + $urandom_range(0, 255);
  endfunction

  // Mostly well-formed packets, many of them replays of recent content so that
  // duplicates, expiry and eviction all occur; the rest is noise and cut-off packets.
  function automatic int gen_packet(int unsigned step);
    pkt_tmpl_t t;
    pkt_item_t it;
    int unsigned r;
    bit drop_last;
    if ($urandom_range(0, 99) < 25) begin
      it = rand_item();
      it.last = ($urandom_range(0, 99) < 20);
      pending_items.push_back(it);
      return 1;
    end
    if (tmpl_pool.size() > 0 && $urandom_range(0, 99) < 40) begin
      t = tmpl_pool[$urandom_range(0, tmpl_pool.size() - 1)];
    end else begin
      t.ptype = 4'($urandom);
      t.pver = 2'($urandom);
      t.route = 2'($urandom);
      if ($urandom_range(0, 99) < 30) begin
        t.ptype = cfg_trace;
        t.route = cfg_direct;
      end
      r = $urandom_range(0, 99);
      if (r < 45) t.plen = 8'(r % 3);
      else t.plen = 8'($urandom);
      r = $urandom_range(0, 99);
      if (r < 70) t.nbytes = $urandom_range(0, 4);
      else if (r < 95) t.nbytes = $urandom_range(5, 10);
      else t.nbytes = $urandom_range(11, 20);
      for (int i = 0; i < 20; i++) t.data[i] = 8'($urandom);
      tmpl_pool.push_back(t);
      if (tmpl_pool.size() > POOL_DEPTH) void'(tmpl_pool.pop_front());
    end
    advance_clock(step);
    drop_last = ($urandom_range(0, 99) < 5);
    push_hdr((t.nbytes == 0) && !drop_last, t.ptype, t.pver, t.route, t.plen,
             1'($urandom), 16'($urandom), 16'($urandom), pkt_clock);
    for (int i = 0; i < t.nbytes; i++)
      push_byte((i == t.nbytes - 1) && !drop_last, t.data[i]);
    return 1 + t.nbytes;
  endfunction

  // Holds the sender off until the block has delivered everything and gone quiet.
  task automatic drain();
    while (pending_items.size() != 0 || start) @(posedge clk);
    while (dedup_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    logic [31:0] word;
    word = value;
    if (idx == CFG_IDX_TRACE) begin
      word = ($urandom & 32'hFFFF_FFF0) | (value & 32'hF);
      cfg_trace = value[3:0];
    end else if (idx == CFG_IDX_DIRECT) begin
      word = ($urandom & 32'hFFFF_FFFC) | (value & 32'h3);
      cfg_direct = value[1:0];
    end else if (idx == CFG_IDX_TIMEOUT) begin
      cfg_timeout = value;
    end
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= word;
  endtask

  task automatic run_phase(int unsigned pct, int unsigned n_items, int unsigned step,
                           logic [31:0] timeout, logic [3:0] trace, logic [1:0] direct);
    int made;
    made = 0;
    drain();
    write_reg(CFG_IDX_TIMEOUT, timeout);
    write_reg(CFG_IDX_TRACE, {28'd0, trace});
    write_reg(CFG_IDX_DIRECT, {30'd0, direct});
    @(negedge clk);
    cfg_we <= 1'b0;
    idle_pct = pct;
    while (made < n_items) made += gen_packet(step);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    idle_pct = 38;

    // Directed part, with the registers at their reset values.
    push_byte(1'b0, 8'hFF);  // payload with no header since reset
    push_byte(1'b1, 8'h00);
    push_hdr(1'b1, 4'd9, 2'd3, 2'd2, 8'd255, 1'b1, 16'hFFFF, 16'h0000, 32'd100);
    push_hdr(1'b1, 4'd9, 2'd3, 2'd2, 8'd255, 1'b0, 16'h0000, 16'hFFFF, 32'd100);
    push_hdr(1'b0, 4'd15, 2'd0, 2'd3, 8'd2, 1'b0, 16'h0000, 16'hFFFF, 32'd200);
    push_byte(1'b0, 8'h00);
    push_byte(1'b1, 8'hFF);
    // An open packet is abandoned when a new header arrives.
    push_hdr(1'b0, 4'd0, 2'd0, 2'd0, 8'd1, 1'b0, 16'hFFFF, 16'hFFFF, 32'd300);
    push_hdr(1'b0, 4'd4, 2'd1, 2'd1, 8'd0, 1'b1, 16'h0000, 16'hFFFF, 32'd300);
    push_byte(1'b1, 8'hAA);
    // One millisecond past the timeout expires the entry; exactly the timeout does not.
    push_hdr(1'b1, 4'd9, 2'd3, 2'd2, 8'd255, 1'b0, 16'h0000, 16'h0000, 32'd60101);
    push_hdr(1'b1, 4'd9, 2'd3, 2'd2, 8'd255, 1'b0, 16'h0000, 16'h0000, 32'd120101);
    push_hdr(1'b1, 4'd9, 2'd3, 2'd2, 8'd254, 1'b0, 16'h0000, 16'h0000, 32'd120101);
    push_hdr(1'b1, 4'd9, 2'd3, 2'd1, 8'd254, 1'b0, 16'h0000, 16'h0000, 32'd120101);
    // Arrival time wraps through zero between the original and the duplicate.
    push_hdr(1'b0, 4'd7, 2'd2, 2'd0, 8'd3, 1'b0, 16'h0000, 16'h1234, 32'hFFFF_FFF0);
    push_byte(1'b0, 8'h55);
    push_byte(1'b1, 8'h66);
    push_hdr(1'b0, 4'd7, 2'd2, 2'd0, 8'd3, 1'b1, 16'h8001, 16'h0000, 32'h0000_0010);
    push_byte(1'b0, 8'h55);
    push_byte(1'b1, 8'h66);
    push_byte(1'b1, 8'h77);  // payload after a closed packet reuses the held header

    run_phase(38, 170, 3, 32'd0, 4'd0, 2'd0);
    drain();
    // The unused register index must leave every register alone.
    write_reg(CFG_IDX_UNUSED, $urandom);
    run_phase(88, 170, 1000, 32'hFFFF_FFFF, 4'd15, 2'd3);
    run_phase(0, 170, 100, 32'd300, 4'($urandom), 2'($urandom));
    run_phase(0, 170, 20000, TIMEOUT_RESET, 4'($urandom), 2'($urandom));
    drain();

    if (dedup_expected.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, dedup_expected.size());
    if (mismatches == 0 && dedup_expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
